[src/beep_sequencer_with_preview_core_macros.svh]
// Assertion macros for the beep sequencer with preview.
// Included by the modules that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef BEEP_SEQUENCER_WITH_PREVIEW_CORE_MACROS_SVH
`define BEEP_SEQUENCER_WITH_PREVIEW_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every clock edge outside reset.
`define BSP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bsp assertion failed");

// Checked at every clock edge, during reset too.
`define BSP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("bsp assertion failed");

`else

`define BSP_ASSERT(label, prop)
`define BSP_ASSERT_ALWAYS(label, prop)

`endif

`endif

[src/bsp_pkg.sv]
// Shared types, codes and helpers of the beep sequencer with preview.
// No dependencies; used by bsp_next and beep_sequencer_with_preview_core.
package bsp_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [2:0] {
    OpTick    = 3'd0,
    OpBeep    = 3'd1,
    OpPreview = 3'd2,
    OpSetVol  = 3'd3,
    OpStop    = 3'd4
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegBeepOnMs    = 2'd0,
    RegPauseMs     = 2'd1,
    RegDutyFloor   = 2'd2,
    RegDutyCeiling = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] beep_on_ms;
    logic [15:0] pause_ms;
    logic [7:0]  duty_floor;
    logic [7:0]  duty_ceiling;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    beep_on_ms:   16'd500,
    pause_ms:     16'd500,
    duty_floor:   8'd10,
    duty_ceiling: 8'd128
  };

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  beep_count;
    logic [15:0] hold_ms;
    logic [7:0]  volume_in;
  } item_t;

  typedef struct packed {
    logic        seq_active;
    logic        in_beep_phase;
    logic [7:0]  beeps_done;
    logic [7:0]  beeps_target;
    logic [15:0] phase_elapsed;
    logic        tone_flag;
    logic [7:0]  volume_duty;
    logic        preview_flag;
    logic [15:0] preview_left;
  } state_t;

  localparam state_t StateReset = '{
    seq_active:    1'b0,
    in_beep_phase: 1'b0,
    beeps_done:    8'd0,
    beeps_target:  8'd0,
    phase_elapsed: 16'd0,
    tone_flag:     1'b0,
    volume_duty:   8'd128,
    preview_flag:  1'b0,
    preview_left:  16'd0
  };

  typedef struct packed {
    logic       tone_on;
    logic [7:0] pwm_duty;
    logic       sequence_active;
    logic       preview_on;
    logic [7:0] beeps_finished;
  } result_t;

  // Zero passes through as mute; the ceiling wins over the floor.
  function automatic logic [7:0] clamp_duty(logic [7:0] vol, logic [7:0] floor_v,
                                            logic [7:0] ceil_v);
    logic [7:0] v;
    v = vol;
    if (v != 8'd0) begin
      if (v < floor_v) begin
        v = floor_v;
      end
      if (v > ceil_v) begin
        v = ceil_v;
      end
    end
    return v;
  endfunction

endpackage

[src/bsp_next.sv]
// Next-state logic of the beep sequencer: applies one event to the sequencer state.
// Depends on bsp_pkg.
module bsp_next (
  input  bsp_pkg::cfg_t   cfg_i,
  input  bsp_pkg::state_t st_i,
  input  bsp_pkg::item_t  item_i,
  output bsp_pkg::state_t st_o
);
  import bsp_pkg::*;

  logic [15:0] pe_inc;
  logic [15:0] pl_dec;
  logic [7:0]  done_inc;

  assign pe_inc   = (st_i.phase_elapsed == 16'hFFFF) ? st_i.phase_elapsed
                                                     : st_i.phase_elapsed + 16'd1;
  assign pl_dec   = (st_i.preview_left == 16'd0) ? 16'd0 : st_i.preview_left - 16'd1;
  assign done_inc = st_i.beeps_done + 8'd1;

  always_comb begin
    st_o = st_i;
    unique case (op_e'(item_i.operation))
      OpTick: begin
        st_o.phase_elapsed = pe_inc;
        st_o.preview_left  = pl_dec;
        if (st_i.preview_flag) begin
          if (st_i.seq_active) begin
            st_o.preview_flag = 1'b0;
          end else if (pl_dec == 16'd0) begin
            st_o.preview_flag = 1'b0;
            st_o.tone_flag    = 1'b0;
          end else begin
            st_o.tone_flag = 1'b1;
          end
        end
        if (st_i.seq_active) begin
          if (st_i.in_beep_phase) begin
            if (pe_inc >= cfg_i.beep_on_ms) begin
              st_o.tone_flag  = 1'b0;
              st_o.beeps_done = done_inc;
              if (done_inc >= st_i.beeps_target) begin
                st_o.seq_active = 1'b0;
              end else begin
                st_o.in_beep_phase = 1'b0;
                st_o.phase_elapsed = 16'd0;
              end
            end
          end else if (pe_inc >= cfg_i.pause_ms) begin
            st_o.tone_flag     = 1'b1;
            st_o.in_beep_phase = 1'b1;
            st_o.phase_elapsed = 16'd0;
          end
        end
      end
      OpBeep: begin
        if (item_i.beep_count != 8'd0) begin
          st_o.seq_active    = 1'b1;
          st_o.beeps_target  = item_i.beep_count;
          st_o.beeps_done    = 8'd0;
          st_o.in_beep_phase = 1'b1;
          st_o.phase_elapsed = 16'd0;
          st_o.tone_flag     = 1'b1;
        end
      end
      OpPreview: begin
        if (!st_i.seq_active) begin
          st_o.preview_flag = 1'b1;
          st_o.preview_left = item_i.hold_ms;
          st_o.tone_flag    = 1'b1;
        end
      end
      OpSetVol: begin
        st_o.volume_duty = clamp_duty(item_i.volume_in, cfg_i.duty_floor,
                                      cfg_i.duty_ceiling);
      end
      OpStop: begin
        if (st_i.seq_active || st_i.preview_flag) begin
          st_o.tone_flag     = 1'b0;
          st_o.seq_active    = 1'b0;
          st_o.in_beep_phase = 1'b0;
          st_o.beeps_done    = 8'd0;
          st_o.beeps_target  = 8'd0;
          st_o.preview_flag  = 1'b0;
        end
      end
      default: begin
        st_o = st_i;
      end
    endcase
  end

endmodule

[src/beep_sequencer_with_preview_core.sv]
// Top level of the beep sequencer with preview: input register, state, result register.
// Depends on bsp_pkg, bsp_next and beep_sequencer_with_preview_core_macros.svh.
//
//   channel | direction | handshake               | payload
//   in      | sink      | in_valid_i / in_stall_o   | operation, beep_count, hold_ms, volume_in
//   out     | source    | out_valid_o / out_stall_i | tone_on, pwm_duty, sequence_active,
//           |           |                           | preview_on, beeps_finished
//   cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat per cycle on both channels when the output is not stalled.
// An accepted beat waits in the input register and moves to the result register once that is empty or not stalled.
// While the result register holds a stalled result, the input register takes one more beat
// and then stalls the input.
// Reset clears the state, restores the register defaults and empties both stages.
`include "beep_sequencer_with_preview_core_macros.svh"

module beep_sequencer_with_preview_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  in_operation_i,
  input  logic [7:0]  in_beep_count_i,
  input  logic [15:0] in_hold_ms_i,
  input  logic [7:0]  in_volume_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_tone_on_o,
  output logic [7:0]  out_pwm_duty_o,
  output logic        out_sequence_active_o,
  output logic        out_preview_on_o,
  output logic [7:0]  out_beeps_finished_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [bsp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bsp_pkg::CfgDataW-1:0] cfg_data_i
);
  import bsp_pkg::*;

  cfg_t    cfg_q, cfg_d;
  state_t  st_q, st_d, st_nxt;
  item_t   item_q;
  logic    in_valid_q;
  result_t res_q;
  logic    out_valid_q;
  logic    advance;
  logic    fire;

  assign advance     = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && advance;
  assign in_stall_o  = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        RegBeepOnMs:    cfg_d.beep_on_ms   = cfg_data_i;
        RegPauseMs:     cfg_d.pause_ms     = cfg_data_i;
        RegDutyFloor:   cfg_d.duty_floor   = cfg_data_i[7:0];
        RegDutyCeiling: cfg_d.duty_ceiling = cfg_data_i[7:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  bsp_next u_next (
    .cfg_i  (cfg_q),
    .st_i   (st_q),
    .item_i (item_q),
    .st_o   (st_nxt)
  );

  assign st_d = fire ? st_nxt : st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CfgReset;
      st_q        <= StateReset;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      st_q  <= st_d;
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= '{
        operation:  in_operation_i,
        beep_count: in_beep_count_i,
        hold_ms:    in_hold_ms_i,
        volume_in:  in_volume_in_i
      };
    end
    if (fire) begin
      res_q <= '{
        tone_on:         st_nxt.tone_flag,
        pwm_duty:        st_nxt.tone_flag ? st_nxt.volume_duty : 8'd0,
        sequence_active: st_nxt.seq_active,
        preview_on:      st_nxt.preview_flag,
        beeps_finished:  st_nxt.beeps_done
      };
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_tone_on_o         = res_q.tone_on;
  assign out_pwm_duty_o        = res_q.pwm_duty;
  assign out_sequence_active_o = res_q.sequence_active;
  assign out_preview_on_o      = res_q.preview_on;
  assign out_beeps_finished_o  = res_q.beeps_finished;

  `BSP_ASSERT(a_duty_needs_tone, out_valid_o |-> (out_tone_on_o || out_pwm_duty_o == 8'd0))
  `BSP_ASSERT(a_seq_below_target, st_q.seq_active |-> (st_q.beeps_done < st_q.beeps_target))
  `BSP_ASSERT_ALWAYS(a_stall_needs_item, in_stall_o |-> in_valid_q)
  `BSP_ASSERT(a_state_holds_idle, !fire |=> (st_q == $past(st_q)))

endmodule
